FILE: rtl/tun_pkg.sv
package tun_pkg;

  // Magnitudes are brought to at most 2^30 before squaring, so they fit 31 bits.
  localparam int MAG_W  = 31;
  localparam int SUM_W  = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;

  localparam logic [63:0] LIMIT = 64'h0000_0000_4000_0000;

endpackage

FILE: rtl/tun_cross.sv
module tun_cross #(
  parameter int COORD_BITS = 24,
  localparam int EW = COORD_BITS + 1,
  localparam int FW = (EW > 32) ? 32 : EW,
  localparam int CW = 2 * FW + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p0_z,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  output logic                         out_valid,
  output logic signed [CW-1:0]         c_x,
  output logic signed [CW-1:0]         c_y,
  output logic signed [CW-1:0]         c_z
);

  localparam int FIT_SH = (EW > 31) ? EW - 31 : 0;

  logic va;
  logic vb;
  logic vc;
  logic signed [EW-1:0] a [3];
  logic signed [EW-1:0] b [3];
  logic [2:0][FW-1:0] fa;
  logic [2:0][FW-1:0] fb;
  logic signed [2*FW-1:0] pr [6];

  // Shifts an edge toward zero until every component magnitude is at most 2^30.
  function automatic logic [2:0][FW-1:0] fit3(input logic signed [EW-1:0] e0,
                                              input logic signed [EW-1:0] e1,
                                              input logic signed [EW-1:0] e2);
    logic [EW-1:0] m [3];
    logic [2:0] ng;
    logic [EW-1:0] mx;
    logic [5:0] s;
    logic [EW-1:0] q;
    logic [2:0][FW-1:0] r;
    ng = {e2[EW-1], e1[EW-1], e0[EW-1]};
    m[0] = e0[EW-1] ? EW'(-e0) : EW'(e0);
    m[1] = e1[EW-1] ? EW'(-e1) : EW'(e1);
    m[2] = e2[EW-1] ? EW'(-e2) : EW'(e2);
    mx = (m[0] > m[1]) ? m[0] : m[1];
    mx = (m[2] > mx) ? m[2] : mx;
    s = '0;
    for (int t = 0; t < FIT_SH; t++) begin
      if ((64'(mx) >> t) > tun_pkg::LIMIT) begin
        s = s + 6'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      q = m[i] >> s;
      r[i] = ng[i] ? FW'(-q) : FW'(q);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a[0] <= EW'(p0_x) - EW'(p1_x);
      a[1] <= EW'(p0_y) - EW'(p1_y);
      a[2] <= EW'(p0_z) - EW'(p1_z);
      b[0] <= EW'(p0_x) - EW'(p2_x);
      b[1] <= EW'(p0_y) - EW'(p2_y);
      b[2] <= EW'(p0_z) - EW'(p2_z);
      fa <= fit3(a[0], a[1], a[2]);
      fb <= fit3(b[0], b[1], b[2]);
      pr[0] <= $signed(fa[1]) * $signed(fb[2]);
      pr[1] <= $signed(fa[2]) * $signed(fb[1]);
      pr[2] <= $signed(fa[2]) * $signed(fb[0]);
      pr[3] <= $signed(fa[0]) * $signed(fb[2]);
      pr[4] <= $signed(fa[0]) * $signed(fb[1]);
      pr[5] <= $signed(fa[1]) * $signed(fb[0]);
      c_x <= CW'(pr[0]) - CW'(pr[1]);
      c_y <= CW'(pr[2]) - CW'(pr[3]);
      c_z <= CW'(pr[4]) - CW'(pr[5]);
    end
  end

endmodule

FILE: rtl/tun_norm.sv
module tun_norm #(
  parameter int CW = 51,
  localparam int MW = CW - 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ce,
  input  logic                              in_valid,
  input  logic signed [CW-1:0]              c_x,
  input  logic signed [CW-1:0]              c_y,
  input  logic signed [CW-1:0]              c_z,
  output logic                              out_valid,
  output logic [2:0][tun_pkg::MAG_W-1:0]    mag,
  output logic [2:0]                        neg,
  output logic                              degen,
  output logic [tun_pkg::SUM_W-1:0]         sum
);

  localparam int KSH = (MW > 31) ? MW - 31 : 0;

  logic ve;
  logic vf;
  logic vg;
  logic [2:0][MW-1:0] me;
  logic [2:0][MW-1:0] me_next;
  logic [MW-1:0] mxe;
  logic [MW-1:0] mxe_next;
  logic [2:0] nege;
  logic dge;
  logic [5:0] k;
  logic [2:0][tun_pkg::MAG_W-1:0] mf;
  logic [2:0][tun_pkg::MAG_W-1:0] mf_next;
  logic [2:0] negf;
  logic dgf;
  logic [2:0][tun_pkg::SUM_W-1:0] sq;
  logic [2:0][tun_pkg::MAG_W-1:0] mg;
  logic [2:0] negg;
  logic dgg;

  always_comb begin
    me_next[0] = c_x[CW-1] ? MW'(-c_x) : MW'(c_x);
    me_next[1] = c_y[CW-1] ? MW'(-c_y) : MW'(c_y);
    me_next[2] = c_z[CW-1] ? MW'(-c_z) : MW'(c_z);
    mxe_next = (me_next[0] > me_next[1]) ? me_next[0] : me_next[1];
    mxe_next = (me_next[2] > mxe_next) ? me_next[2] : mxe_next;
  end

  always_comb begin
    k = '0;
    for (int t = 0; t < KSH; t++) begin
      if ((64'(mxe) >> t) > tun_pkg::LIMIT) begin
        k = k + 6'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      mf_next[i] = tun_pkg::MAG_W'(me[i] >> k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      ve <= in_valid;
      vf <= ve;
      vg <= vf;
      out_valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      me <= me_next;
      mxe <= mxe_next;
      nege <= {c_z[CW-1], c_y[CW-1], c_x[CW-1]};
      dge <= (c_x == '0) && (c_y == '0) && (c_z == '0);
      mf <= mf_next;
      negf <= nege;
      dgf <= dge;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= mf[i] * mf[i];
      end
      mg <= mf;
      negg <= negf;
      dgg <= dgf;
      sum <= sq[0] + sq[1] + sq[2];
      mag <= mg;
      neg <= negg;
      degen <= dgg;
    end
  end

endmodule

FILE: rtl/tun_sqrt.sv
module tun_sqrt #(
  parameter int SB_W = 97
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [tun_pkg::SUM_W-1:0]     radicand,
  input  logic [SB_W-1:0]               sb_in,
  output logic                          out_valid,
  output logic [tun_pkg::ROOT_W-1:0]    root,
  output logic [SB_W-1:0]               sb_out
);

  localparam int RW = tun_pkg::ROOT_W;
  localparam int SW = tun_pkg::SUM_W;
  localparam int REM_W = RW + 3;

  logic v [1:RW];
  logic [SW-1:0] rad [1:RW];
  logic [RW-1:0] rt [1:RW];
  logic [REM_W-1:0] rm [1:RW];
  logic [SB_W-1:0] sb [1:RW];

  for (genvar j = 0; j < RW; j++) begin : g_st
    logic cv;
    logic [SW-1:0] crad;
    logic [RW-1:0] crt;
    logic [REM_W-1:0] crm;
    logic [SB_W-1:0] csb;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic ge;

    if (j == 0) begin : g_src
      assign cv = in_valid;
      assign crad = radicand;
      assign crt = '0;
      assign crm = '0;
      assign csb = sb_in;
    end else begin : g_src
      assign cv = v[j];
      assign crad = rad[j];
      assign crt = rt[j];
      assign crm = rm[j];
      assign csb = sb[j];
    end

    assign rem_sh = {crm[REM_W-3:0], crad[SW-1 -: 2]};
    assign trial = {1'b0, crt, 2'b01};
    assign ge = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (ce) begin
        v[j+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rad[j+1] <= crad << 2;
        rt[j+1] <= {crt[RW-2:0], ge};
        rm[j+1] <= ge ? rem_sh - trial : rem_sh;
        sb[j+1] <= csb;
      end
    end
  end

  assign out_valid = v[RW];
  assign root = rt[RW];
  assign sb_out = sb[RW];

endmodule

FILE: rtl/tun_div.sv
module tun_div #(
  parameter int QW = 15,
  parameter int SB_W = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ce,
  input  logic                            in_valid,
  input  logic [2:0][tun_pkg::MAG_W-1:0]  mag,
  input  logic [tun_pkg::ROOT_W-1:0]      root,
  input  logic [SB_W-1:0]                 sb_in,
  output logic                            out_valid,
  output logic [2:0][QW-1:0]              quot,
  output logic [SB_W-1:0]                 sb_out
);

  localparam int NW = tun_pkg::MAG_W + QW;
  localparam int DW = tun_pkg::ROOT_W + 1;

  logic v [1:QW];
  logic [2:0][NW-1:0] rm [1:QW];
  logic [2:0][QW-1:0] q [1:QW];
  logic [DW-1:0] d [1:QW];
  logic [SB_W-1:0] sb [1:QW];
  logic [2:0][NW-1:0] num;

  // Numerator is mag * 2^QW + r and the divisor is 2r, which rounds half up.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = (NW'(mag[l]) << QW) + NW'(root);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_st
    localparam int B = QW - 1 - j;
    logic cv;
    logic [2:0][NW-1:0] crm;
    logic [2:0][QW-1:0] cq;
    logic [DW-1:0] cd;
    logic [SB_W-1:0] csb;
    logic [NW-1:0] dsh;
    logic [2:0][NW-1:0] rm_next;
    logic [2:0][QW-1:0] q_next;

    if (j == 0) begin : g_src
      assign cv = in_valid;
      assign crm = num;
      assign cq = '0;
      assign cd = {root, 1'b0};
      assign csb = sb_in;
    end else begin : g_src
      assign cv = v[j];
      assign crm = rm[j];
      assign cq = q[j];
      assign cd = d[j];
      assign csb = sb[j];
    end

    assign dsh = NW'(cd) << B;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        q_next[l] = cq[l];
        q_next[l][B] = crm[l] >= dsh;
        rm_next[l] = q_next[l][B] ? crm[l] - dsh : crm[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (ce) begin
        v[j+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rm[j+1] <= rm_next;
        q[j+1] <= q_next;
        d[j+1] <= cd;
        sb[j+1] <= csb;
      end
    end
  end

  assign out_valid = v[QW];
  assign quot = q[QW];
  assign sb_out = sb[QW];

endmodule

FILE: rtl/triangle_unit_normal_core.sv
// Unit face normal of one triangle per transfer.
// The input channel (in_valid, in_stall) carries the three vertices p0, p1 and
// p2 as signed Q11.12 coordinates. The output channel (out_valid, out_stall)
// carries the normal of (p0 - p1) x (p0 - p2) as three signed Q1.14 values,
// rounded to nearest, and a degenerate flag. A zero cross product gives a zero
// normal with degenerate set.
// One triangle is accepted every cycle while the output is not stalled. The
// pipeline has four stages for edges and cross product, four for scaling
// and the squared length, one per root bit in the square root (31), one
// per quotient bit in the three dividers (NORMAL_BITS - 1), and the output
// register.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block keeps no state between triangles.
module triangle_unit_normal_core #(
  parameter int COORD_BITS = 24,
  parameter int NORMAL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  p0_x,
  input  logic signed [COORD_BITS-1:0]  p0_y,
  input  logic signed [COORD_BITS-1:0]  p0_z,
  input  logic signed [COORD_BITS-1:0]  p1_x,
  input  logic signed [COORD_BITS-1:0]  p1_y,
  input  logic signed [COORD_BITS-1:0]  p1_z,
  input  logic signed [COORD_BITS-1:0]  p2_x,
  input  logic signed [COORD_BITS-1:0]  p2_y,
  input  logic signed [COORD_BITS-1:0]  p2_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORMAL_BITS-1:0] normal_x,
  output logic signed [NORMAL_BITS-1:0] normal_y,
  output logic signed [NORMAL_BITS-1:0] normal_z,
  output logic                          degenerate
);

  localparam int EW = COORD_BITS + 1;
  localparam int FW = (EW > 32) ? 32 : EW;
  localparam int CW = 2 * FW + 1;
  localparam int F = NORMAL_BITS - 2;
  localparam int QW = F + 1;
  localparam int MW3 = 3 * tun_pkg::MAG_W;
  localparam int SQ_SB = MW3 + 4;
  localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};

  logic ce;
  logic cv;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;
  logic signed [CW-1:0] c_z;
  logic nv;
  logic [2:0][tun_pkg::MAG_W-1:0] mag;
  logic [2:0] neg;
  logic degen;
  logic [tun_pkg::SUM_W-1:0] sum;
  logic sv;
  logic [tun_pkg::ROOT_W-1:0] root;
  logic [SQ_SB-1:0] sq_sb;
  logic dv;
  logic [2:0][QW-1:0] quot;
  logic [3:0] dv_sb;

  function automatic logic signed [NORMAL_BITS-1:0] finish(input logic [QW-1:0] q,
                                                           input logic n,
                                                           input logic dg);
    logic [QW-1:0] c;
    c = (q > ONE_Q) ? ONE_Q : q;
    if (dg) begin
      return '0;
    end
    return n ? -NORMAL_BITS'(c) : NORMAL_BITS'(c);
  endfunction

  assign ce = !(out_valid && out_stall);
  assign in_stall = !ce;

  tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(in_valid),
    .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
    .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
    .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
    .out_valid(cv), .c_x(c_x), .c_y(c_y), .c_z(c_z)
  );

  tun_norm #(.CW(CW)) u_norm (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(cv),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .out_valid(nv), .mag(mag), .neg(neg), .degen(degen), .sum(sum)
  );

  tun_sqrt #(.SB_W(SQ_SB)) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(nv),
    .radicand(sum), .sb_in({degen, neg, mag}),
    .out_valid(sv), .root(root), .sb_out(sq_sb)
  );

  tun_div #(.QW(QW), .SB_W(4)) u_div (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(sv),
    .mag(sq_sb[MW3-1:0]), .root(root), .sb_in(sq_sb[SQ_SB-1:MW3]),
    .out_valid(dv), .quot(quot), .sb_out(dv_sb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && dv) begin
      normal_x <= finish(quot[0], dv_sb[0], dv_sb[3]);
      normal_y <= finish(quot[1], dv_sb[1], dv_sb[3]);
      normal_z <= finish(quot[2], dv_sb[2], dv_sb[3]);
      degenerate <= dv_sb[3];
    end
  end

endmodule

FILE: rtl/tun_check.sv
module tun_check #(
  parameter int COORD_BITS = 24,
  parameter int NORMAL_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [COORD_BITS-1:0]  p0_x,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [NORMAL_BITS-1:0] normal_x,
  input logic signed [NORMAL_BITS-1:0] normal_y,
  input logic signed [NORMAL_BITS-1:0] normal_z,
  input logic                          degenerate
);

  localparam logic signed [NORMAL_BITS-1:0] ONE = NORMAL_BITS'(1) << (NORMAL_BITS - 2);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(degenerate))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |->
      normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE && normal_y >= -ONE &&
      normal_z <= ONE && normal_z >= -ONE &&
      (normal_x != '0 || normal_y != '0 || normal_z != '0))
    else $error("normal component out of range or zero");

  a_p0_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !$isunknown(p0_x))
    else $error("transfer with unknown vertex");

endmodule

bind triangle_unit_normal_core tun_check #(
  .COORD_BITS(COORD_BITS),
  .NORMAL_BITS(NORMAL_BITS)
) u_tun_check (.*);

FILE: sim/triangle_unit_normal_core_test.sv
`timescale 1ns / 1ps

module triangle_unit_normal_core_test;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  class normal_scoreboard;
    normal_t pending[$];
    int      errors;

    static function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (x >= res + bit_v) begin
          x = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return res;
    endfunction

    static function normal_t face_normal(logic signed [23:0] p[9]);
      longint      a[3], b[3], c[3];
      logic [63:0] mag[3], mx, s2, r, n, unit;
      int          k;
      normal_t     res;
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'(p[i]) - longint'(p[3 + i]);
        b[i] = longint'(p[i]) - longint'(p[6 + i]);
      end
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) return res;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i] < 0 ? -c[i] : c[i];
        if (mag[i] > mx) mx = mag[i];
      end
      k = 0;
      while ((mx >> k) > 64'd1073741824) k++;
      s2 = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> k;
        s2 = s2 + mag[i] * mag[i];
      end
      r = root_floor(s2);
      if (r == 0) r = 1;
      unit = 64'd1 << 14;
      for (int i = 0; i < 3; i++) begin
        n = ((mag[i] << 15) + r) / (2 * r);
        if (n > unit) n = unit;
        if (c[i] < 0) n = -n;
        if (i == 0) res.nx = n[15:0];
        else if (i == 1) res.ny = n[15:0];
        else res.nz = n[15:0];
      end
      res.degen = 1'b0;
      return res;
    endfunction

    function void note_triangle(logic signed [23:0] p[9]);
      pending.push_back(face_normal(p));
    endfunction

    function void check_normal(normal_t got);
      normal_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
          got.degen !== want.degen) begin
        $display("%0t: expected %0d %0d %0d %b, actual %0d %0d %0d %b", $time,
                 want.nx, want.ny, want.nz, want.degen,
                 got.nx, got.ny, got.nz, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [23:0] p0_x = 0, p0_y = 0, p0_z = 0;
  logic signed [23:0] p1_x = 0, p1_y = 0, p1_z = 0;
  logic signed [23:0] p2_x = 0, p2_y = 0, p2_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic degenerate;

  int idle_pct = 0;
  int stall_pct = 0;
  normal_scoreboard board = new();

  triangle_unit_normal_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
    .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
    .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_normal('{normal_x, normal_y, normal_z, degenerate});
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_triangle(logic signed [23:0] p[9]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {p0_x, p0_y, p0_z} <= {p[0], p[1], p[2]};
    {p1_x, p1_y, p1_z} <= {p[3], p[4], p[5]};
    {p2_x, p2_y, p2_z} <= {p[6], p[7], p[8]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_triangle(p);
  endtask

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'(int'($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? 24'sh7fffff : -24'sh800000;
      default: return 24'(int'($urandom_range(3)) - 1);
    endcase
  endfunction

  task automatic send_random(int count);
    logic signed [23:0] p[9];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(3);
      foreach (p[i]) p[i] = rand_coord(mode);
      case ($urandom_range(9))
        0: p[3:5] = p[0:2];
        1: foreach (p[i]) if (i >= 6) p[i] = p[i - 6] + 24'sd2 * (p[i - 3] - p[i - 6]);
        default: ;
      endcase
      send_triangle(p);
    end
    in_valid <= 0;
  endtask

  initial begin
    logic signed [23:0] p[9];
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(p);
    p = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096};
    send_triangle(p);
    p = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0};
    send_triangle(p);
    p = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, -24'sh800000, 24'sh7fffff,
          -24'sh800000, 24'sh7fffff, -24'sh800000, -24'sh800000};
    send_triangle(p);
    p = '{-24'sh800000, -24'sh800000, -24'sh800000, 24'sh7fffff, -24'sh800000,
          24'sh7fffff, -24'sh800000, 24'sh7fffff, 24'sh7fffff};
    send_triangle(p);
    p = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    send_triangle(p);
    p = '{5, 5, 5, 5, 5, 5, 9, 1, 2};
    send_triangle(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(p);
    p = '{0, 0, 0, -1, 0, 0, 0, -1, 0};
    send_triangle(p);
    p = '{0, 0, 0, 24'sh7fffff, 0, 0, 0, 0, 1};
    send_triangle(p);
    p = '{-24'sh800000, 0, 0, 24'sh7fffff, 0, 0, 0, 24'sh7fffff, 0};
    send_triangle(p);
    in_valid <= 0;
    send_random(300);
    idle_pct = 56;
    send_random(300);
    idle_pct = 0;
    stall_pct = 56;
    send_random(300);
    idle_pct = 38;
    stall_pct = 38;
    send_random(350);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: triangle_unit_normal_core.f
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_norm.sv
rtl/tun_sqrt.sv
rtl/tun_div.sv
rtl/triangle_unit_normal_core.sv
rtl/tun_check.sv
sim/triangle_unit_normal_core_test.sv
